>>> rtl/mwo_pkg.sv
package mwo_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_W = 128;

    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_LENGTH    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_REV = 8'd3;

    localparam logic [15:0] RST_WHEEL_RADIUS   = 16'd4588;
    localparam logic [15:0] RST_HALF_LENGTH    = 16'd13107;
    localparam logic [15:0] RST_HALF_WIDTH     = 16'd11076;
    localparam logic [15:0] RST_COUNTS_PER_REV = 16'd42;

    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic [29:0] NS_PER_S = 30'd1000000000;

    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_DT_MUL   = 4'd2;
    localparam logic [3:0] OP_DT_ADD   = 4'd3;
    localparam logic [3:0] OP_SEL_SUM  = 4'd4;
    localparam logic [3:0] OP_MUL      = 4'd5;
    localparam logic [3:0] OP_MUL_END  = 4'd6;
    localparam logic [3:0] OP_NUM_SAVE = 4'd7;
    localparam logic [3:0] OP_SHIFT    = 4'd8;
    localparam logic [3:0] OP_DIV_INIT = 4'd9;
    localparam logic [3:0] OP_DIV_STEP = 4'd10;
    localparam logic [3:0] OP_STORE    = 4'd11;
    localparam logic [3:0] OP_OUT      = 4'd12;

    localparam logic [2:0] BSEL_RADIUS = 3'd0;
    localparam logic [2:0] BSEL_PI     = 3'd1;
    localparam logic [2:0] BSEL_NS     = 3'd2;
    localparam logic [2:0] BSEL_CPR    = 3'd3;
    localparam logic [2:0] BSEL_EXTRA  = 3'd4;

    localparam logic [1:0] IDX_FORWARD = 2'd0;
    localparam logic [1:0] IDX_SIDE    = 2'd1;
    localparam logic [1:0] IDX_YAW     = 2'd2;

    localparam logic [4:0] MUL_LAST = 5'd5;
    localparam logic [4:0] DIV_LAST = 5'd31;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] idx;
        logic [2:0] bsel;
        logic [4:0] step;
    } cmd_t;

    typedef struct packed {
        logic dt_le0;
    } status_t;

endpackage

>>> rtl/mwo_ctrl.sv
module mwo_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output mwo_pkg::cmd_t   cmd,
    input  mwo_pkg::status_t status
);
    import mwo_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DTMUL  = 4'd1;
    localparam logic [3:0] S_DTADD  = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_SUM    = 4'd4;
    localparam logic [3:0] S_NMUL   = 4'd5;
    localparam logic [3:0] S_NSAVE  = 4'd6;
    localparam logic [3:0] S_DMUL   = 4'd7;
    localparam logic [3:0] S_SHIFT  = 4'd8;
    localparam logic [3:0] S_DINIT  = 4'd9;
    localparam logic [3:0] S_DSTEP  = 4'd10;
    localparam logic [3:0] S_STORE  = 4'd11;
    localparam logic [3:0] S_FINISH = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic [1:0] mcnt_reg, mcnt_next;
    logic [1:0] idx_reg, idx_next;
    logic       first_reg, first_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            mcnt_reg      <= '0;
            idx_reg       <= '0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            mcnt_reg      <= mcnt_next;
            idx_reg       <= idx_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        mcnt_next      = mcnt_reg;
        idx_next       = idx_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        cmd.idx        = idx_reg;
        cmd.bsel       = BSEL_RADIUS;
        cmd.step       = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    if (first_reg)
                    begin
                        first_next = 1'b0;
                    end
                    else
                    begin
                        state_next = S_DTMUL;
                    end
                end
            end
            S_DTMUL:
            begin
                cmd.op     = OP_DT_MUL;
                state_next = S_DTADD;
            end
            S_DTADD:
            begin
                cmd.op     = OP_DT_ADD;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                idx_next = IDX_FORWARD;
                if (status.dt_le0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.op     = OP_SEL_SUM;
                step_next  = '0;
                mcnt_next  = '0;
                state_next = S_NMUL;
            end
            S_NMUL:
            begin
                case (mcnt_reg)
                    2'd0:    cmd.bsel = BSEL_RADIUS;
                    2'd1:    cmd.bsel = BSEL_PI;
                    default: cmd.bsel = BSEL_NS;
                endcase
                if (step_reg == MUL_LAST)
                begin
                    cmd.op    = OP_MUL_END;
                    step_next = '0;
                    if (mcnt_reg == 2'd2)
                    begin
                        mcnt_next  = '0;
                        state_next = S_NSAVE;
                    end
                    else
                    begin
                        mcnt_next = mcnt_reg + 2'd1;
                    end
                end
                else
                begin
                    cmd.op    = OP_MUL;
                    step_next = step_reg + 5'd1;
                end
            end
            S_NSAVE:
            begin
                cmd.op     = OP_NUM_SAVE;
                state_next = S_DMUL;
            end
            S_DMUL:
            begin
                cmd.bsel = (mcnt_reg == 2'd0) ? BSEL_CPR : BSEL_EXTRA;
                if (step_reg == MUL_LAST)
                begin
                    cmd.op    = OP_MUL_END;
                    step_next = '0;
                    if (mcnt_reg == 2'd0 && idx_reg == IDX_YAW)
                    begin
                        mcnt_next = 2'd1;
                    end
                    else
                    begin
                        mcnt_next  = '0;
                        state_next = S_SHIFT;
                    end
                end
                else
                begin
                    cmd.op    = OP_MUL;
                    step_next = step_reg + 5'd1;
                end
            end
            S_SHIFT:
            begin
                cmd.op     = OP_SHIFT;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.op     = OP_DIV_INIT;
                step_next  = '0;
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.op = OP_DIV_STEP;
                if (step_reg == DIV_LAST)
                begin
                    step_next  = '0;
                    state_next = S_STORE;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            S_STORE:
            begin
                cmd.op = OP_STORE;
                if (idx_reg == IDX_YAW)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = S_SUM;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/mwo_datapath.sv
module mwo_datapath #(
    parameter int FRAC_BITS = mwo_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mwo_pkg::cmd_t                  cmd,
    output mwo_pkg::status_t               status,
    input  logic                           cfg_write,
    input  logic [mwo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mwo_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [31:0]                    time_sec,
    input  logic [29:0]                    time_nsec,
    input  logic signed [31:0]             ticks_wheel_1,
    input  logic signed [31:0]             ticks_wheel_2,
    input  logic signed [31:0]             ticks_wheel_3,
    input  logic signed [31:0]             ticks_wheel_4,
    output logic [31:0]                    stamp_sec,
    output logic [29:0]                    stamp_nsec,
    output logic signed [31:0]             speed_forward,
    output logic signed [31:0]             speed_side,
    output logic signed [31:0]             yaw_rate,
    output logic                           time_error
);
    import mwo_pkg::*;

    localparam int SH_LIN = 47 - FRAC_BITS;
    localparam int SH_YAW = 31 - FRAC_BITS;
    localparam logic signed [30:0] NS_S = {1'b0, NS_PER_S};

    logic [15:0] radius_reg, hlen_reg, hwid_reg, cpr_reg;

    logic [31:0] prev_sec_reg, hold_sec_reg;
    logic [29:0] prev_nsec_reg, hold_nsec_reg;
    logic [31:0] prev_t0_reg, prev_t1_reg, prev_t2_reg, prev_t3_reg;
    logic signed [31:0] d0_reg, d1_reg, d2_reg, d3_reg;
    logic signed [31:0] dsec_reg;
    logic signed [30:0] dnsec_reg;
    logic signed [62:0] dtm_reg;
    logic signed [63:0] dt_reg;

    logic [NUM_W-1:0] acc_reg, res_reg, num_reg, den_reg, rem_reg;
    logic [63:0]      prod_reg;
    logic [33:0]      mag_reg;
    logic             neg_reg;
    logic             ovf_reg;
    logic [31:0]      q_reg;
    logic [31:0]      work_reg [0:2];

    logic [16:0]        extra;
    logic [31:0]        bval;
    logic [31:0]        chunk;
    logic [1:0]         sh_sel;
    logic signed [34:0] e0, e1, e2, e3, sum_sel;
    logic [34:0]        sum_abs;
    logic [62:0]        dtm_next;
    logic [4:0]         bit_pos;
    logic [NUM_W:0]     rtmp;
    logic [NUM_W:0]     den_ext;
    logic               rge;
    logic [31:0]        lim;
    logic [31:0]        val_mag;
    logic [31:0]        val_out;
    logic               dt_le0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RST_WHEEL_RADIUS;
            hlen_reg   <= RST_HALF_LENGTH;
            hwid_reg   <= RST_HALF_WIDTH;
            cpr_reg    <= RST_COUNTS_PER_REV;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WHEEL_RADIUS:   radius_reg <= cfg_data;
                REG_HALF_LENGTH:    hlen_reg   <= cfg_data;
                REG_HALF_WIDTH:     hwid_reg   <= cfg_data;
                REG_COUNTS_PER_REV: cpr_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign extra = {1'b0, hlen_reg} + {1'b0, hwid_reg};

    always_comb
    begin
        case (cmd.bsel)
            BSEL_RADIUS: bval = {16'd0, radius_reg};
            BSEL_PI:     bval = PI_Q30;
            BSEL_NS:     bval = {2'd0, NS_PER_S};
            BSEL_CPR:    bval = (cpr_reg == 16'd0) ? 32'd1 : {16'd0, cpr_reg};
            BSEL_EXTRA:  bval = {15'd0, extra};
            default:     bval = 32'd0;
        endcase
    end

    assign chunk  = acc_reg[{cmd.step[1:0], 5'd0} +: 32];
    assign sh_sel = 2'(cmd.step[1:0] - 2'd1);

    assign e0 = {{3{d0_reg[31]}}, d0_reg};
    assign e1 = {{3{d1_reg[31]}}, d1_reg};
    assign e2 = {{3{d2_reg[31]}}, d2_reg};
    assign e3 = {{3{d3_reg[31]}}, d3_reg};

    always_comb
    begin
        case (cmd.idx)
            IDX_FORWARD: sum_sel = e0 + e1 + e2 + e3;
            IDX_SIDE:    sum_sel = e1 + e3 - e0 - e2;
            default:     sum_sel = e1 + e2 - e0 - e3;
        endcase
    end

    assign sum_abs  = sum_sel[34] ? 35'(-sum_sel) : sum_sel;
    assign dtm_next = dsec_reg * NS_S;

    assign bit_pos = 5'(DIV_LAST - cmd.step);
    assign rtmp    = {rem_reg, num_reg[{2'd0, bit_pos}]};
    assign den_ext = {1'b0, den_reg};
    assign rge     = (rtmp >= den_ext);

    always_comb
    begin
        lim     = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        val_mag = (ovf_reg || (q_reg > lim)) ? lim : q_reg;
        if (mag_reg == 34'd0)
        begin
            val_mag = 32'd0;
        end
        else if (cmd.idx == IDX_YAW && extra == 17'd0)
        begin
            val_mag = lim;
        end
        val_out = neg_reg ? 32'(-val_mag) : val_mag;
    end

    assign dt_le0        = dt_reg[63] || (dt_reg == 64'sd0);
    assign status.dt_le0 = dt_le0;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                d0_reg        <= 32'(ticks_wheel_1 - prev_t0_reg);
                d1_reg        <= 32'(ticks_wheel_2 - prev_t1_reg);
                d2_reg        <= 32'(ticks_wheel_3 - prev_t2_reg);
                d3_reg        <= 32'(ticks_wheel_4 - prev_t3_reg);
                dsec_reg      <= 32'(time_sec - prev_sec_reg);
                dnsec_reg     <= 31'({1'b0, time_nsec} - {1'b0, prev_nsec_reg});
                hold_sec_reg  <= prev_sec_reg;
                hold_nsec_reg <= prev_nsec_reg;
                prev_sec_reg  <= time_sec;
                prev_nsec_reg <= time_nsec;
                prev_t0_reg   <= ticks_wheel_1;
                prev_t1_reg   <= ticks_wheel_2;
                prev_t2_reg   <= ticks_wheel_3;
                prev_t3_reg   <= ticks_wheel_4;
            end
            OP_DT_MUL:
            begin
                dtm_reg <= dtm_next;
            end
            OP_DT_ADD:
            begin
                dt_reg <= {dtm_reg[62], dtm_reg} + {{33{dnsec_reg[30]}}, dnsec_reg};
            end
            OP_SEL_SUM:
            begin
                neg_reg <= sum_sel[34];
                mag_reg <= sum_abs[33:0];
                acc_reg <= {94'd0, sum_abs[33:0]};
            end
            OP_MUL:
            begin
                if (cmd.step[2] == 1'b0)
                begin
                    prod_reg <= chunk * bval;
                end
                if (cmd.step == 5'd0)
                begin
                    res_reg <= '0;
                end
                else
                begin
                    res_reg <= res_reg + ({64'd0, prod_reg} << {sh_sel, 5'd0});
                end
            end
            OP_MUL_END:
            begin
                acc_reg <= res_reg;
            end
            OP_NUM_SAVE:
            begin
                num_reg <= acc_reg;
                acc_reg <= {64'd0, dt_reg};
            end
            OP_SHIFT:
            begin
                den_reg <= (cmd.idx == IDX_YAW) ? (acc_reg << SH_YAW) : (acc_reg << SH_LIN);
            end
            OP_DIV_INIT:
            begin
                rem_reg <= {32'd0, num_reg[NUM_W-1:32]};
                ovf_reg <= ({32'd0, num_reg[NUM_W-1:32]} >= den_reg);
                q_reg   <= '0;
            end
            OP_DIV_STEP:
            begin
                rem_reg <= rge ? NUM_W'(rtmp - den_ext) : rtmp[NUM_W-1:0];
                q_reg   <= {q_reg[30:0], rge};
            end
            OP_STORE:
            begin
                case (cmd.idx)
                    IDX_FORWARD: work_reg[0] <= val_out;
                    IDX_SIDE:    work_reg[1] <= val_out;
                    default:     work_reg[2] <= val_out;
                endcase
            end
            OP_OUT:
            begin
                stamp_sec     <= hold_sec_reg;
                stamp_nsec    <= hold_nsec_reg;
                speed_forward <= dt_le0 ? 32'sd0 : work_reg[0];
                speed_side    <= dt_le0 ? 32'sd0 : work_reg[1];
                yaw_rate      <= dt_le0 ? 32'sd0 : work_reg[2];
                time_error    <= dt_le0;
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> rtl/mecanum_wheel_odometry.sv
// Mecanum wheel odometry. Each input transaction carries one sample: a
// timestamp and four encoder counts. The first sample after reset only
// primes the stored previous sample and produces no output transaction.
// Every later sample produces one output transaction with the forward and
// side speeds and the yaw rate as signed fixed point values, stamped with
// the previous sample's time. When the time difference is not positive the
// speeds are zero and time_error is set.
// A sample is computed by a shared 32 by 32 multiplier, applied in four
// partial products per wide multiply, and a one bit per cycle divider that
// runs 32 steps per speed. For a sample that produces output, out_valid is
// set in the same cycle that in_ready returns; in_ready stays low while a
// sample is computed, so a sample is accepted only after the previous one
// is finished. A sample with a non-positive time difference skips the speeds.
// The output register holds a finished result while the next sample is
// accepted; if the receiver stalls, the following result waits inside the
// block and no further sample is taken until it moves on.
// The configuration channel is always ready. Reset restores the default
// geometry registers and clears the primed flag and the output valid.
module mecanum_wheel_odometry #(
    parameter int FRAC_BITS = mwo_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [31:0]                    time_sec,
    input  logic [29:0]                    time_nsec,
    input  logic signed [31:0]             ticks_wheel_1,
    input  logic signed [31:0]             ticks_wheel_2,
    input  logic signed [31:0]             ticks_wheel_3,
    input  logic signed [31:0]             ticks_wheel_4,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [31:0]                    stamp_sec,
    output logic [29:0]                    stamp_nsec,
    output logic signed [31:0]             speed_forward,
    output logic signed [31:0]             speed_side,
    output logic signed [31:0]             yaw_rate,
    output logic                           time_error,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mwo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mwo_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mwo_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    mwo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    mwo_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .time_sec      (time_sec),
        .time_nsec     (time_nsec),
        .ticks_wheel_1 (ticks_wheel_1),
        .ticks_wheel_2 (ticks_wheel_2),
        .ticks_wheel_3 (ticks_wheel_3),
        .ticks_wheel_4 (ticks_wheel_4),
        .stamp_sec     (stamp_sec),
        .stamp_nsec    (stamp_nsec),
        .speed_forward (speed_forward),
        .speed_side    (speed_side),
        .yaw_rate      (yaw_rate),
        .time_error    (time_error)
    );

endmodule
